### rtl/length_prefixed_message_queue_defines.svh
// Assertion macros shared by the message queue RTL.
// Each macro takes a label, an antecedent and a consequent, and samples on
// the rising edge of clk with the check held off while rst_n is low.
`ifndef LENGTH_PREFIXED_MESSAGE_QUEUE_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS

`define LPMQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpmq assertion failed");

`define LPMQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpmq assertion failed");

`else

`define LPMQ_ASSERT_SAME(lbl, ante, cons)

`define LPMQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/lpmq_pkg.sv
`default_nettype none

package lpmq_pkg;

  // Result status codes.
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_PUSH_REJECT = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY   = 2'd2;
  localparam logic [1:0] ST_POP_BADLEN  = 2'd3;

  // Input command codes.
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Bytes of length prefix in front of every stored message.
  localparam int unsigned LEN_PREFIX = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // latch the accepted input word
    logic       cnt_clr;   // clear the byte counter
    logic       rd_start;  // load the read pointer with the oldest message start
    logic       wr;        // write one byte at the write pointer
    logic       rd;        // issue one byte read at the read pointer
    logic       commit;    // update the fill count and load the result register
    logic [1:0] status;    // status to commit
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_pop;
    logic push_ok;
    logic pop_empty;
    logic bad_len;
    logic wr_last;
    logic len_done;
    logic rd_more;
    logic rd_pend;
    logic out_valid;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/length_prefixed_message_queue.sv
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid, in_stall   | command, msg_len, payload_low, payload_high
// out_     | output    | out_valid, out_stall | status, len, low, high, fill_level
//
// Each command is decoded and then worked through the single byte-wide ring memory,
// which moves one length or payload byte per cycle. A rejected push or an empty pop goes
// straight from decode to the result commit, and a pop with a bad stored length is
// refused once its length prefix has been read.
// Reset is synchronous and active low; it empties the queue but leaves the memory as is.
// A result waits in the output register while the next word is accepted and worked on;
// only the commit of that next result waits for out_stall to release.
`default_nettype none

module length_prefixed_message_queue #(
  parameter int RING_BYTES    = 256,
  parameter int MAX_MSG_BYTES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel: one command word per handshake.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [4:0]  in_msg_len,
  input  wire logic [63:0] in_payload_low,
  input  wire logic [63:0] in_payload_high,
  // Result channel: exactly one result word per command word.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [4:0]       out_len,
  output logic [63:0]      out_low,
  output logic [63:0]      out_high,
  output logic [8:0]       out_fill_level
);

  // The controller sequences each command word through decode, the byte loop
  // and the result commit. The datapath owns the ring memory, the write pointer,
  // the fill count and the result register.
  lpmq_pkg::ctrl_cmd_t cmd;
  lpmq_pkg::dp_sts_t   sts;

  lpmq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpmq_datapath #(
    .RING_BYTES   (RING_BYTES),
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_command     (in_command),
    .in_msg_len     (in_msg_len),
    .in_payload_low (in_payload_low),
    .in_payload_high(in_payload_high),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_len        (out_len),
    .out_low        (out_low),
    .out_high       (out_high),
    .out_fill_level (out_fill_level)
  );

endmodule

`default_nettype wire

### rtl/lpmq_ram.sv
`default_nettype none

module lpmq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

### rtl/lpmq_ctrl.sv
`default_nettype none
`include "length_prefixed_message_queue_defines.svh"

module lpmq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               out_stall,
  input  wire lpmq_pkg::dp_sts_t  sts,
  output lpmq_pkg::ctrl_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_PUSH = 3'd2;
  localparam logic [2:0] S_LEN  = 3'd3;
  localparam logic [2:0] S_LENW = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_POP  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic [1:0] status_r;
  logic [1:0] status_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    cmd          = '0;
    cmd.status   = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.cnt_clr = 1'b1;
        if (sts.is_pop) begin
          if (sts.pop_empty) begin
            status_nxt = lpmq_pkg::ST_POP_EMPTY;
            state_nxt  = S_DONE;
          end else begin
            cmd.rd_start = 1'b1;
            state_nxt    = S_LEN;
          end
        end else begin
          if (sts.push_ok) begin
            state_nxt = S_PUSH;
          end else begin
            status_nxt = lpmq_pkg::ST_PUSH_REJECT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_PUSH: begin
        cmd.wr = 1'b1;
        if (sts.wr_last) begin
          status_nxt = lpmq_pkg::ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_LEN: begin
        cmd.rd = 1'b1;
        if (sts.len_done) begin
          state_nxt = S_LENW;
        end
      end
      S_LENW: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.bad_len) begin
          status_nxt = lpmq_pkg::ST_POP_BADLEN;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (sts.rd_more) begin
          cmd.rd = 1'b1;
        end else if (!sts.rd_pend) begin
          status_nxt = lpmq_pkg::ST_OK;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= lpmq_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  `LPMQ_ASSERT_NEXT(a_badlen_reported, (state_r == S_CHK) && sts.bad_len,
                    (state_r == S_DONE) && (status_r == lpmq_pkg::ST_POP_BADLEN))
  `LPMQ_ASSERT_SAME(a_pop_states_only_for_pop,
                    (state_r == S_LEN) || (state_r == S_CHK) || (state_r == S_POP),
                    sts.is_pop)
  `LPMQ_ASSERT_SAME(a_commit_into_free_slot, cmd.commit, !(sts.out_valid && out_stall))

endmodule

`default_nettype wire

### rtl/lpmq_datapath.sv
`default_nettype none
`include "length_prefixed_message_queue_defines.svh"

module lpmq_datapath #(
  parameter int RING_BYTES    = 256,
  parameter int MAX_MSG_BYTES = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_command,
  input  wire logic [4:0]          in_msg_len,
  input  wire logic [63:0]         in_payload_low,
  input  wire logic [63:0]         in_payload_high,
  input  wire logic                out_stall,
  input  wire lpmq_pkg::ctrl_cmd_t cmd,
  output lpmq_pkg::dp_sts_t        sts,
  output logic                     out_valid,
  output logic [1:0]               out_status,
  output logic [4:0]               out_len,
  output logic [63:0]              out_low,
  output logic [63:0]              out_high,
  output logic [8:0]               out_fill_level
);

  localparam int PW = $clog2(RING_BYTES);
  localparam int CW = $clog2(RING_BYTES + 1);

  logic              cmd_pop_r;
  logic [4:0]        msg_len_r;
  logic [127:0]      pay_r;
  logic [15:0]       len_r;
  logic [PW-1:0]     wp_r;
  logic [PW-1:0]     rp_r;
  logic [CW-1:0]     stored_r;
  logic [CW-1:0]     stored_nxt;
  logic [4:0]        cnt_r;
  logic              rv_r;
  logic [4:0]        ridx_r;
  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [4:0]        out_len_r;
  logic [127:0]      out_data_r;
  logic [8:0]        out_fill_r;

  logic [PW-1:0]     wp_inc;
  logic [PW-1:0]     rp_inc;
  logic [CW-1:0]     head_gap;
  logic [CW:0]       start_sum;
  logic [CW:0]       start_wrap;
  logic [CW:0]       room;
  logic [16:0]       avail;
  logic [4:0]        wsel;
  logic [4:0]        rsel;
  logic [7:0]        wbyte;
  logic [7:0]        rdata;
  logic              ok_pop;
  logic [CW+8:0]     fill_wide;

  assign wp_inc = (wp_r == PW'(RING_BYTES - 1)) ? '0 : wp_r + PW'(1);
  assign rp_inc = (rp_r == PW'(RING_BYTES - 1)) ? '0 : rp_r + PW'(1);

  // Oldest message start: write pointer minus fill count, modulo the ring size.
  assign head_gap   = CW'(RING_BYTES) - stored_r;
  assign start_sum  = (CW+1)'(wp_r) + {1'b0, head_gap};
  assign start_wrap = (start_sum >= (CW+1)'(RING_BYTES)) ?
                      start_sum - (CW+1)'(RING_BYTES) : start_sum;

  assign room  = {1'b0, stored_r} + (CW+1)'(msg_len_r) + (CW+1)'(lpmq_pkg::LEN_PREFIX);
  assign avail = 17'(stored_r) - 17'(lpmq_pkg::LEN_PREFIX);

  assign wsel = cnt_r - 5'd2;
  assign rsel = ridx_r - 5'd2;

  always_comb begin
    case (cnt_r)
      5'd0:    wbyte = {3'b000, msg_len_r};
      5'd1:    wbyte = 8'h00;
      default: wbyte = pay_r[{wsel[3:0], 3'b000} +: 8];
    endcase
  end

  lpmq_ram #(
    .WIDTH(8),
    .DEPTH(RING_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(wp_r),
    .wdata(wbyte),
    .raddr(rp_r),
    .rdata(rdata)
  );

  always_comb begin
    sts.is_pop    = cmd_pop_r;
    sts.push_ok   = (msg_len_r != 5'd0) && (msg_len_r <= 5'(MAX_MSG_BYTES)) &&
                    (room <= (CW+1)'(RING_BYTES));
    sts.pop_empty = (stored_r <= CW'(lpmq_pkg::LEN_PREFIX));
    sts.bad_len   = ({1'b0, len_r} > avail) || (len_r > 16'(MAX_MSG_BYTES));
    sts.wr_last   = (cnt_r == msg_len_r + 5'd1);
    sts.len_done  = (cnt_r == 5'd1);
    sts.rd_more   = (17'(cnt_r) < 17'(len_r) + 17'(lpmq_pkg::LEN_PREFIX));
    sts.rd_pend   = rv_r;
    sts.out_valid = out_valid_r;
  end

  assign ok_pop = cmd_pop_r && (cmd.status == lpmq_pkg::ST_OK);

  always_comb begin
    stored_nxt = stored_r;
    if (cmd.status == lpmq_pkg::ST_OK) begin
      if (cmd_pop_r) begin
        stored_nxt = stored_r - CW'(len_r[4:0]) - CW'(lpmq_pkg::LEN_PREFIX);
      end else begin
        stored_nxt = stored_r + CW'(msg_len_r) + CW'(lpmq_pkg::LEN_PREFIX);
      end
    end
  end

  assign fill_wide = {9'b0, stored_nxt};

  // Item registers and read capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_pop_r <= in_command;
      msg_len_r <= in_msg_len;
      len_r     <= '0;
      pay_r     <= (in_command == lpmq_pkg::CMD_POP) ? '0 :
                   {in_payload_high, in_payload_low};
    end else if (rv_r) begin
      case (ridx_r)
        5'd0:    len_r[7:0]  <= rdata;
        5'd1:    len_r[15:8] <= rdata;
        default: pay_r[{rsel[3:0], 3'b000} +: 8] <= rdata;
      endcase
    end
    if (cmd.rd_start) begin
      rp_r <= start_wrap[PW-1:0];
    end else if (cmd.rd) begin
      rp_r <= rp_inc;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.wr || cmd.rd) begin
      cnt_r <= cnt_r + 5'd1;
    end
    ridx_r <= cnt_r;
    if (cmd.commit) begin
      out_status_r <= cmd.status;
      out_len_r    <= ok_pop ? len_r[4:0] : '0;
      out_data_r   <= ok_pop ? pay_r : '0;
      out_fill_r   <= fill_wide[8:0];
    end
  end

  // Queue state and control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      stored_r    <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.wr) begin
        wp_r <= wp_inc;
      end
      if (cmd.commit) begin
        stored_r <= stored_nxt;
      end
      rv_r <= cmd.rd;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_len        = out_len_r;
  assign out_low        = out_data_r[63:0];
  assign out_high       = out_data_r[127:64];
  assign out_fill_level = out_fill_r;

  `LPMQ_ASSERT_SAME(a_fill_in_range, 1'b1, stored_r <= CW'(RING_BYTES))
  `LPMQ_ASSERT_SAME(a_wp_in_range, 1'b1, wp_r <= PW'(RING_BYTES - 1))
  `LPMQ_ASSERT_SAME(a_read_index_in_range, rv_r, ridx_r <= 5'd17)

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int RING_BYTES    = 256;
  localparam int MAX_MSG_BYTES = 16;
  // Longest run of cycles with no word accepted on either channel before the
  // run is declared hung. The worst legal case is a long sender gap, the
  // slowest pop and a long result stall back to back.
  localparam int HANG_LIMIT    = 2000;
  // Cycles to keep watching the result channel once every result has come.
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_WORDS  = 1950;

  // One command word as it crosses the input channel.
  typedef struct {
    logic        cmd;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
  } msg_word_t;

  // One result word as it should appear on the result channel.
  typedef struct {
    logic [1:0]  status;
    logic [4:0]  len;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [8:0]  fill;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = lpmq_pkg::CMD_PUSH;
  logic [4:0]  in_msg_len = '0;
  logic [63:0] in_payload_low = '0;
  logic [63:0] in_payload_high = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [4:0]  out_len;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic [8:0]  out_fill_level;

  length_prefixed_message_queue #(
    .RING_BYTES   (RING_BYTES),
    .MAX_MSG_BYTES(MAX_MSG_BYTES)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_msg_len     (in_msg_len),
    .in_payload_low (in_payload_low),
    .in_payload_high(in_payload_high),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_len        (out_len),
    .out_low        (out_low),
    .out_high       (out_high),
    .out_fill_level (out_fill_level)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Command words waiting to be sent, and result words the queue owes us.
  msg_word_t     cmd_backlog[$];
  queue_result_t awaited_results[$];
  int            error_count = 0;

  // Our own image of the queue: the byte ring, the write pointer and the
  // number of bytes stored. The ring starts unknown, exactly like the memory
  // in the block, and only bytes inside the stored region are ever read.
  logic [7:0] ring_image[RING_BYTES];
  int         head_ptr = 0;
  int         fill_bytes = 0;

  // Applies one accepted command word to the queue image and returns the
  // result word it must produce. A push stores a two-byte little-endian
  // length and then the payload; a pop takes the oldest message back out.
  function automatic queue_result_t apply_command(input msg_word_t w);
    queue_result_t r;
    int            rd;
    int            slen;
    r.status = lpmq_pkg::ST_OK;
    r.len    = '0;
    r.lo     = '0;
    r.hi     = '0;
    if (w.cmd == lpmq_pkg::CMD_PUSH) begin
      // Zero length, oversized and no-room pushes all leave the queue alone.
      if (w.len == 0 || w.len > MAX_MSG_BYTES ||
          fill_bytes + lpmq_pkg::LEN_PREFIX + w.len > RING_BYTES) begin
        r.status = lpmq_pkg::ST_PUSH_REJECT;
      end else begin
        ring_image[head_ptr] = {3'b000, w.len};
        head_ptr = (head_ptr + 1) % RING_BYTES;
        ring_image[head_ptr] = 8'h00;
        head_ptr = (head_ptr + 1) % RING_BYTES;
        // Payload bytes past the length are dropped.
        for (int i = 0; i < w.len; i++) begin
          ring_image[head_ptr] = (i < 8) ? w.lo[8*i +: 8] : w.hi[8*(i-8) +: 8];
          head_ptr = (head_ptr + 1) % RING_BYTES;
        end
        fill_bytes += lpmq_pkg::LEN_PREFIX + w.len;
      end
    end else begin
      if (fill_bytes <= lpmq_pkg::LEN_PREFIX) begin
        r.status = lpmq_pkg::ST_POP_EMPTY;
      end else begin
        // The oldest message starts fill_bytes behind the write pointer.
        rd   = (head_ptr + RING_BYTES - fill_bytes) % RING_BYTES;
        slen = {ring_image[(rd + 1) % RING_BYTES], ring_image[rd]};
        rd   = (rd + 2) % RING_BYTES;
        // A stored length that overruns the stored bytes or the message
        // maximum is refused and the queue is left as it was.
        if (slen > fill_bytes - lpmq_pkg::LEN_PREFIX || slen > MAX_MSG_BYTES) begin
          r.status = lpmq_pkg::ST_POP_BADLEN;
        end else begin
          for (int i = 0; i < slen; i++) begin
            if (i < 8) r.lo[8*i +: 8] = ring_image[rd];
            else r.hi[8*(i-8) +: 8] = ring_image[rd];
            rd = (rd + 1) % RING_BYTES;
          end
          fill_bytes -= lpmq_pkg::LEN_PREFIX + slen;
          r.len = slen[4:0];
        end
      end
    end
    r.fill = fill_bytes[8:0];
    return r;
  endfunction

  // Calm stretches turn off idling on both sides so that the block also sees
  // words back to back with the result channel always open.
  logic calm = 1'b0;
  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap(input logic calm_now);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_now || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver. A word is accepted at an edge where in_valid is high and
  // in_stall is low; the expected result is worked out right then, so the
  // image of the queue always follows the order of acceptance. While a word
  // is stalled nothing on the input side changes.
  msg_word_t   held_word;
  int unsigned send_gap = 0;

  always @(posedge clk) begin : drive_words
    msg_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) awaited_results.push_back(apply_command(held_word));
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (cmd_backlog.size() != 0) begin
        w               = cmd_backlog.pop_front();
        held_word       = w;
        in_command      <= w.cmd;
        in_msg_len      <= w.len;
        in_payload_low  <= w.lo;
        in_payload_high <= w.hi;
        in_valid        <= 1'b1;
        send_gap        <= pick_gap(calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back pressure: random stall bursts, none during calm spells.
  int unsigned stall_left = 0;

  always @(posedge clk) begin : stall_results
    int unsigned n;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      n = pick_gap(calm);
      out_stall  <= (n != 0);
      stall_left <= (n != 0) ? n - 1 : 0;
    end
  end

  function automatic void check_field(input string what, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      error_count++;
    end
  endfunction

  // Monitor. Every accepted result word is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : watch_results
    queue_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual status %0d",
                 $time, out_status);
        error_count++;
      end else begin
        e = awaited_results.pop_front();
        check_field("status", e.status, out_status);
        check_field("len", e.len, out_len);
        check_field("low", e.lo, out_low);
        check_field("high", e.hi, out_high);
        check_field("fill_level", e.fill, out_fill_level);
      end
    end
  end

  // Watchdog: too long without any word moving on either channel means the
  // block has hung.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("%0t: no word accepted for %0d cycles", $time, HANG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic add_push(input int len, input logic [63:0] lo, input logic [63:0] hi);
    msg_word_t w;
    w.cmd = lpmq_pkg::CMD_PUSH;
    w.len = len[4:0];
    w.lo  = lo;
    w.hi  = hi;
    cmd_backlog.push_back(w);
  endtask

  task automatic add_pop();
    msg_word_t w;
    // The payload fields of a pop mean nothing, so they carry noise.
    w.cmd = lpmq_pkg::CMD_POP;
    w.len = $urandom_range(0, 31);
    w.lo  = {$urandom, $urandom};
    w.hi  = {$urandom, $urandom};
    cmd_backlog.push_back(w);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin : stimulus
    int unsigned made;
    int unsigned phase_words;
    int unsigned push_odds;
    int unsigned pick;
    logic [63:0] lo;
    logic [63:0] hi;

    // Directed words. A pop on the empty queue, the three ways a push is
    // refused for its length, the shortest and longest messages with
    // extreme payloads, and then a fill to exactly full followed by a push
    // that finds no room.
    add_pop();
    add_push(0, '1, '1);
    add_push(MAX_MSG_BYTES + 1, '1, '1);
    add_push(31, '1, '1);
    add_push(1, '1, '1);
    add_pop();
    add_push(MAX_MSG_BYTES, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    add_pop();
    for (int i = 0; i < 14; i++) add_push(MAX_MSG_BYTES, rand64(), rand64());
    add_push(2, '1, '0);
    add_push(1, rand64(), rand64());

    // Random words in phases that lean toward pushing, toward popping or
    // toward neither, so the queue keeps swinging between full and empty
    // and the pointers wrap around the ring many times.
    made = 0;
    while (made < RANDOM_WORDS) begin
      phase_words = $urandom_range(10, 60);
      pick        = $urandom_range(0, 2);
      push_odds   = (pick == 0) ? 85 : (pick == 1) ? 55 : 20;
      for (int i = 0; i < phase_words; i++) begin
        if ($urandom_range(0, 99) < push_odds) begin
          lo = rand64();
          hi = rand64();
          pick = $urandom_range(0, 19);
          if (pick == 0) lo = '1;
          else if (pick == 1) hi = '0;
          // Most pushes are legal; the rest use any length the field holds.
          if ($urandom_range(0, 99) < 88) add_push($urandom_range(1, MAX_MSG_BYTES), lo, hi);
          else add_push($urandom_range(0, 31), lo, hi);
        end else begin
          add_pop();
        end
      end
      made += phase_words;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word has been sent and every result has come back,
    // sampling away from the active edge, then watch for stray results.
    @(negedge clk);
    while (cmd_backlog.size() != 0 || in_valid) @(negedge clk);
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lpmq_pkg.sv
rtl/lpmq_ram.sv
rtl/lpmq_ctrl.sv
rtl/lpmq_datapath.sv
rtl/length_prefixed_message_queue.sv
tb/sv/tb.sv
